// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

	typedef enum logic [1:0] {
		CMD_PRINT = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	localparam logic [7:0] CHAR_BS    = 8'd8;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [7:0] BLANK_ATTR_RESET = 8'hF0;
	localparam logic [3:0] COLOR_MASK       = 4'hF;

	// Side effects of one print character on the cell store.
	typedef struct packed {
		logic write_cell;
		logic scroll;
	} print_flags_t;

endpackage

// ===== sv/tcw_if.sv =====
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  char_code;
	logic [3:0]  foreground;
	logic [3:0]  background;
	logic [10:0] cell_index;

	modport source (output valid, command, char_code, foreground, background, cell_index,
		input ready);
	modport sink (input valid, command, char_code, foreground, background, cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;

	modport source (output valid, cursor_pos, cell_data, input ready);
	modport sink (input valid, cursor_pos, cell_data, output ready);
endinterface

// ===== sv/text_console_writer.sv =====
// Top level of the text console writer: sequencer, cursor, ring-mapped cell store.
// Print and unused commands pass through the done state, which loads the output register once it is
// free and returns to idle, where the next word is taken; read first passes the read state for the memory read.
// Scroll blanks one row through the single write port.
// Clear blanks the whole store, one cell a cycle.
// After reset the store is swept to blank, with no request taken until the sweep ends.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_req_if.sink     request,
	tcw_rsp_if.source   response,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
	localparam logic [AW:0]   COLS_X  = (AW + 1)'(COLUMNS);
	localparam logic [AW:0]   CELLS_X = (AW + 1)'(CELL_COUNT);
	localparam logic [AW-1:0] LAST_A  = AW'(CELL_COUNT - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] sweep_last_q;
	logic [15:0]   fill_q;
	logic [15:0]   data_q;
	logic          rd_range_q;
	logic [7:0]    blank_attr_q;
	logic          out_valid_q;
	logic [10:0]   out_loc_q;
	logic [15:0]   out_data_q;

	logic [CW-1:0]         col_next;
	logic [RW-1:0]         row_next;
	tcw_pkg::print_flags_t flags;

	logic          accept;
	logic [AW-1:0] cur_lin;
	logic [AW-1:0] cur_phys;
	logic [AW-1:0] rd_phys;
	logic          rd_in_range;
	logic [AW:0]   base_step;
	logic [15:0]   blank;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [15:0]   ram_rdata;

	// Map a logical cell number onto the ring of rows; base is the top row's first cell.
	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] lin,
		input logic [AW-1:0] base);
		logic [AW:0] sum;
		sum = {1'b0, lin} + {1'b0, base};
		if (sum >= CELLS_X) begin
			sum = sum - CELLS_X;
		end
		return sum[AW-1:0];
	endfunction

	assign request.ready  = (state_q == ST_IDLE);
	assign accept         = request.valid && request.ready;
	assign cur_lin        = AW'(row_q) * COLS_A + AW'(col_q);
	assign cur_phys       = to_phys(cur_lin, base_q);
	assign rd_phys        = to_phys(AW'(request.cell_index), base_q);
	assign rd_in_range    = 32'(request.cell_index) < 32'(CELL_COUNT);
	assign base_step      = {1'b0, base_q} + COLS_X;
	assign blank          = {blank_attr_q, tcw_pkg::SPACE_CHAR};

	assign response.valid      = out_valid_q;
	assign response.cursor_pos = out_loc_q;
	assign response.cell_data  = out_data_q;

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.col      (col_q),
		.row      (row_q),
		.char_code(request.char_code),
		.col_next (col_next),
		.row_next (row_next),
		.flags    (flags)
	);

	// Reads only start from idle, never while a write is in progress, so no forwarding.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR, ST_SCROLL: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && request.command == tcw_pkg::CMD_PRINT && flags.write_cell) begin
					ram_we    = 1'b1;
					ram_waddr = cur_phys;
					ram_wdata = {request.background & tcw_pkg::COLOR_MASK,
						request.foreground & tcw_pkg::COLOR_MASK, request.char_code};
				end
				if (accept && request.command == tcw_pkg::CMD_READ) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	tcw_cell_ram #(
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_cell_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_phys),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= tcw_pkg::BLANK_ATTR_RESET;
		end else if (cfg_we) begin
			blank_attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			sweep_q      <= '0;
			sweep_last_q <= LAST_A;
			fill_q       <= {tcw_pkg::BLANK_ATTR_RESET, tcw_pkg::SPACE_CHAR};
			data_q       <= '0;
			rd_range_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_loc_q    <= '0;
			out_data_q   <= '0;
		end else begin
			// the done state reloads the output register itself
			if (response.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_q == sweep_last_q) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						data_q <= '0;
						case (request.command)
							tcw_pkg::CMD_PRINT: begin
								col_q <= col_next;
								row_q <= row_next;
								if (flags.scroll) begin
									// drop the old top row: it becomes the blank bottom row
									sweep_q      <= base_q;
									sweep_last_q <= base_q + COLS_A - AW'(1);
									base_q       <= (base_step == CELLS_X) ? '0 : base_step[AW-1:0];
									fill_q       <= blank;
									state_q      <= ST_SCROLL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							tcw_pkg::CMD_CLEAR: begin
								col_q        <= '0;
								row_q        <= '0;
								base_q       <= '0;
								sweep_q      <= '0;
								sweep_last_q <= LAST_A;
								fill_q       <= blank;
								state_q      <= ST_CLEAR;
							end
							tcw_pkg::CMD_READ: begin
								rd_range_q <= rd_in_range;
								state_q    <= ST_READ;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					data_q  <= rd_range_q ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_CLEAR, ST_SCROLL: begin
					if (sweep_q == sweep_last_q) begin
						state_q <= ST_DONE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || response.ready) begin
						out_valid_q <= 1'b1;
						out_loc_q   <= 11'(cur_lin);
						out_data_q  <= data_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/tcw_cell_ram.sv =====
// Cell store: one write port, one read port, registered read data.
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/tcw_cursor.sv =====
// Next cursor position for one print character, with wrap and scroll detection.
module tcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CW      = $clog2(COLUMNS),
	parameter int RW      = $clog2(ROWS)
) (
	input  logic [CW-1:0]             col,
	input  logic [RW-1:0]             row,
	input  logic [7:0]                char_code,
	output logic [CW-1:0]             col_next,
	output logic [RW-1:0]             row_next,
	output tcw_pkg::print_flags_t     flags
);

	// Room for a tab past the last column and for one row past the last.
	localparam int CXW = $clog2(COLUMNS + 8);
	localparam int RXW = $clog2(ROWS + 1);

	logic [CXW-1:0] c;
	logic [RXW-1:0] r;

	always_comb begin
		c     = CXW'(col);
		r     = RXW'(row);
		flags = '0;
		case (char_code)
			tcw_pkg::CHAR_BS: begin
				if (col == '0) begin
					c = CXW'(COLUMNS - 1);
					if (row != '0) begin
						r = r - RXW'(1);
					end
				end else begin
					c = c - CXW'(1);
				end
			end
			tcw_pkg::CHAR_TAB: begin
				c = (c + CXW'(8)) & ~CXW'(7);
			end
			tcw_pkg::CHAR_CR: begin
				c = '0;
			end
			tcw_pkg::CHAR_LF: begin
				c = '0;
				r = r + RXW'(1);
			end
			default: begin
				flags.write_cell = 1'b1;
				c = c + CXW'(1);
			end
		endcase
		if (c >= CXW'(COLUMNS)) begin
			c = '0;
			r = r + RXW'(1);
		end
		if (r >= RXW'(ROWS)) begin
			r = RXW'(ROWS - 1);
			flags.scroll = 1'b1;
		end
		col_next = CW'(c);
		row_next = RW'(r);
	end

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checks for the text console writer and the bind that attaches them.
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] out_loc,
	input logic [15:0] out_data
);

	localparam int CELL_COUNT = ROWS * COLUMNS;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_loc) && $stable(out_data))
		else $error("response word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while the previous one is in flight");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_command == tcw_pkg::CMD_CLEAR |-> ##2 !in_ready)
		else $error("request taken during screen clear");

	a_loc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CELL_COUNT > 2048) || (32'(out_loc) < 32'(CELL_COUNT)))
		else $error("cursor location outside the screen");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (request.valid),
	.in_ready  (request.ready),
	.in_command(request.command),
	.out_valid (response.valid),
	.out_ready (response.ready),
	.out_loc   (response.cursor_pos),
	.out_data  (response.cell_data)
);
